### hdl/frl_pkg.sv
// ---------------------------------------------------------------------------
// frl_pkg: shared types and constants of the frequency residency limiter
// Level range, offset window, divide-by-five constants, register indexes
// and register reset values.
// ---------------------------------------------------------------------------
package frl_pkg;

  // Cap level range
  localparam int LEVELS = 32;
  localparam logic signed [7:0] LEVEL_MAX = 8'(LEVELS - 1);

  // Adaptive offset: one step is STEP_MS, the window WINDOW_MS
  localparam int STEP_MS   = 2;
  localparam int WINDOW_MS = 300;
  localparam int OFFSET_LIM_INT = (WINDOW_MS / STEP_MS > 255) ? 255 : WINDOW_MS / STEP_MS;
  localparam logic [7:0]  OFFSET_LIM     = 8'(OFFSET_LIM_INT);
  localparam logic [32:0] OFFSET_STEP_NS = 33'(STEP_MS * 1000000);

  // Decay to 4/5: floor(x/5) for x < 2^34 as (x * ceil(2^36/5)) >> 36
  localparam logic [33:0] DIV5_MAGIC = 34'd13743895348;
  // (2^32 - 1) / 5, so that 2^32 = 5 * DIV5_WORD + 1
  localparam logic [34:0] DIV5_WORD  = 35'd858993459;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_LIMIT_FREQ   = 3'd0,
    REG_LIMIT_LEVEL  = 3'd1,
    REG_TOP_LEVEL    = 3'd2,
    REG_BUDGET       = 3'd3,
    REG_DOWN_STEP    = 3'd4,
    REG_DOWN_INTERVAL = 3'd5,
    REG_UP_STEP      = 3'd6,
    REG_UP_INTERVAL  = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [23:0] RST_LIMIT_FREQ    = 24'd2112000;
  localparam logic [4:0]  RST_LIMIT_LEVEL   = 5'd12;
  localparam logic [4:0]  RST_TOP_LEVEL     = 5'd31;
  localparam logic [31:0] RST_BUDGET        = 32'd30000000;
  localparam logic [5:0]  RST_DOWN_STEP     = 6'd2;
  localparam logic [31:0] RST_DOWN_INTERVAL = 32'd50000000;
  localparam logic [5:0]  RST_UP_STEP       = 6'd1;
  localparam logic [31:0] RST_UP_INTERVAL   = 32'd50000000;

  // Request kinds
  typedef enum logic {
    REQ_UPDATE     = 1'b0,
    REQ_IDLE_RESET = 1'b1
  } req_kind_t;

endpackage

### hdl/frequency_residency_limiter_unit.sv
// ---------------------------------------------------------------------------
// frequency_residency_limiter_unit: per-cluster frequency cap governor
// Tracks residency at or above a limit frequency, adapts its threshold and
// steps a cap level down or up, rate limited, with forced unlock.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one item per update (tuser = request kind, tdata = timestamp,
//           current and floor frequency, isolated flag).
//   out_* : one result item per input item: cap level and over-budget flag,
//           in the order the items were accepted.
//   cfg_* : register writes; the user must write only while no item is in flight; the block does not enforce this.
// Path: an accepted item is taken into the input register, worked on
//   combinationally from there, and its result is registered in the
//   output register once that register is free to take it.
// Throughput: one item per cycle while out_tready stays high. The state loop
//   (accumulator, offset, level, timestamps) closes combinationally around the input register.
// Reset: registers take their reset values, the accumulator, offset and
//   timestamps clear and the level goes to the top level.
// Stall: while out_tready is low the result holds; one more item is taken
//   into the input register, then in_tready drops until the result leaves.
// ---------------------------------------------------------------------------
module frequency_residency_limiter_unit (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,  // now_ns[62:0], cur_freq_khz[86:63],
                                  // floor_freq_khz[110:87], isolated[111]
  input  logic         in_tuser,  // req_type[0]
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata, // cap_level[4:0], over_budget[5], zero[7:6]
  // configuration port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // Input register
  logic        in_vld_r;
  logic        req_r;
  logic [62:0] now_r;
  logic [23:0] cur_r;
  logic [23:0] flo_r;
  logic        iso_r;

  // Output register
  logic       out_vld_r;
  logic [4:0] cap_r;
  logic       ovr_r;
  logic [4:0] cap_nxt;
  logic       ovr_nxt;

  // Configuration registers
  logic [23:0] lim_freq_r;
  logic [4:0]  lim_lvl_r;
  logic [4:0]  top_lvl_r;
  logic [31:0] budget_r;
  logic [5:0]  dn_step_r;
  logic [31:0] dn_int_r;
  logic [5:0]  up_step_r;
  logic [31:0] up_int_r;

  // Governor state
  logic [63:0] accum_r,  accum_nxt;
  logic [62:0] prev_r,   prev_nxt;
  logic [62:0] last_r,   last_nxt;
  logic [4:0]  level_r,  level_nxt;
  logic [7:0]  off_r,    off_nxt;

  // Datapath
  logic        adv;
  logic        started;
  logic [62:0] prev_eff;
  logic [62:0] last_eff;
  logic        force_unlock;
  logic [62:0] delta;
  logic [62:0] upd;
  logic [64:0] sum_ext;
  logic [63:0] add_sat;
  logic [34:0] dv_hi;
  logic [34:0] dv_lo;
  logic [63:0] decay_val;
  logic [63:0] acc_upd;
  logic        above_base;
  logic [7:0]  off_inc;
  logic [7:0]  off_upd;
  logic [32:0] thr_inc;
  logic [32:0] thr_cur;
  logic        over_upd;
  logic [4:0]  lvl_top;
  logic [4:0]  lvl_dn;
  logic [4:0]  lvl_up;

  // floor(x/5) and x mod 5 for a 34-bit x: {rem[2:0], quo[31:0]}
  function automatic logic [34:0] div5(input logic [33:0] x);
    logic [67:0] prod;
    logic [31:0] quo;
    logic [33:0] back;
    prod = 68'(x) * 68'(frl_pkg::DIV5_MAGIC);
    quo  = prod[67:36];
    back = (34'(quo) << 2) + 34'(quo);
    return {3'(x - back), quo};
  endfunction

  // Limit a signed level to 0 .. LEVELS-1
  function automatic logic [4:0] clamp_level(input logic signed [7:0] v);
    logic signed [7:0] c;
    c = v;
    if (c < 8'sd0) begin
      c = 8'sd0;
    end
    if (c > frl_pkg::LEVEL_MAX) begin
      c = frl_pkg::LEVEL_MAX;
    end
    return c[4:0];
  endfunction

  // Threshold for a given offset
  function automatic logic [32:0] thr_of(input logic [31:0] base, input logic [7:0] o);
    return 33'(base) + 33'(o) * frl_pkg::OFFSET_STEP_NS;
  endfunction

  // Handshake: the item in the input register moves when the output is free
  assign adv        = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready  = ~in_vld_r | adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, ovr_r, cap_r};

  // Timestamps: first update takes now as both stored times
  assign started  = (prev_r != 63'd0);
  assign prev_eff = started ? prev_r : now_r;
  assign last_eff = started ? last_r : now_r;
  assign force_unlock = (flo_r >= lim_freq_r) | iso_r;
  assign delta = (force_unlock || now_r < prev_eff) ? 63'd0 : now_r - prev_eff;
  assign upd   = (now_r < last_eff) ? 63'd0 : now_r - last_eff;

  // Residency add, saturating
  assign sum_ext = {1'b0, accum_r} + 65'(delta);
  assign add_sat = sum_ext[64] ? '1 : sum_ext[63:0];

  // Decay to floor(4a/5) from the two 32-bit halves
  assign dv_hi = div5({accum_r[63:32], 2'b00});
  assign dv_lo = div5({accum_r[31:0], 2'b00});
  assign decay_val = {dv_hi[31:0], 32'd0}
                   + 64'(35'(dv_hi[34:32]) * frl_pkg::DIV5_WORD)
                   + 64'(dv_lo[31:0])
                   + 64'((4'(dv_hi[34:32]) + 4'(dv_lo[34:32])) >= 4'd5);

  assign acc_upd = force_unlock ? 64'd0 :
                   (cur_r >= lim_freq_r) ? add_sat : decay_val;

  // Offset adaptation and threshold test
  assign above_base = (acc_upd >= 64'(budget_r));
  assign off_inc    = (off_r >= frl_pkg::OFFSET_LIM) ? frl_pkg::OFFSET_LIM : off_r + 8'd1;
  assign off_upd    = above_base ? off_inc : (off_r >> 1);
  assign thr_inc    = thr_of(budget_r, off_inc);
  assign thr_cur    = thr_of(budget_r, off_r);
  assign over_upd   = above_base & (acc_upd >= 64'(thr_inc));

  // Candidate levels
  assign lvl_top = clamp_level($signed({3'b000, top_lvl_r}));
  always_comb begin
    logic signed [7:0] vd;
    logic signed [7:0] vu;
    vd = $signed({3'b000, level_r}) - $signed({2'b00, dn_step_r});
    if (vd < $signed({3'b000, lim_lvl_r})) begin
      vd = $signed({3'b000, lim_lvl_r});
    end
    vu = $signed({3'b000, level_r}) + $signed({2'b00, up_step_r});
    if (vu > $signed({3'b000, top_lvl_r})) begin
      vu = $signed({3'b000, top_lvl_r});
    end
    lvl_dn = clamp_level(vd);
    lvl_up = clamp_level(vu);
  end

  // Next state and result of the item in the input register
  always_comb begin
    accum_nxt = accum_r;
    prev_nxt  = prev_r;
    last_nxt  = last_r;
    level_nxt = level_r;
    off_nxt   = off_r;
    if (req_r == frl_pkg::REQ_IDLE_RESET) begin
      if (iso_r) begin
        accum_nxt = 64'd0;
        prev_nxt  = now_r;
        last_nxt  = now_r;
        level_nxt = lvl_top;
      end
      ovr_nxt = ((iso_r ? 64'd0 : accum_r) >= 64'(thr_cur));
    end else begin
      accum_nxt = acc_upd;
      off_nxt   = off_upd;
      prev_nxt  = now_r;
      last_nxt  = last_eff;
      if (over_upd) begin
        if (upd >= 63'(dn_int_r)) begin
          level_nxt = lvl_dn;
          last_nxt  = now_r;
        end
      end else begin
        if (upd >= 63'(up_int_r)) begin
          level_nxt = lvl_up;
          last_nxt  = now_r;
        end
      end
      if (force_unlock) begin
        level_nxt = lvl_top;
      end
      ovr_nxt = over_upd;
    end
    cap_nxt = level_nxt;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= (in_tvalid & in_tready) | (in_vld_r & ~adv);
    end
    if (in_tvalid && in_tready) begin
      req_r <= in_tuser;
      now_r <= in_tdata[62:0];
      cur_r <= in_tdata[86:63];
      flo_r <= in_tdata[110:87];
      iso_r <= in_tdata[111];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= adv | (out_vld_r & ~out_tready);
    end
    if (adv) begin
      cap_r <= cap_nxt;
      ovr_r <= ovr_nxt;
    end
  end

  // Governor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= 64'd0;
      prev_r  <= 63'd0;
      last_r  <= 63'd0;
      level_r <= clamp_level($signed({3'b000, frl_pkg::RST_TOP_LEVEL}));
      off_r   <= 8'd0;
    end else if (adv) begin
      accum_r <= accum_nxt;
      prev_r  <= prev_nxt;
      last_r  <= last_nxt;
      level_r <= level_nxt;
      off_r   <= off_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_freq_r <= frl_pkg::RST_LIMIT_FREQ;
      lim_lvl_r  <= frl_pkg::RST_LIMIT_LEVEL;
      top_lvl_r  <= frl_pkg::RST_TOP_LEVEL;
      budget_r   <= frl_pkg::RST_BUDGET;
      dn_step_r  <= frl_pkg::RST_DOWN_STEP;
      dn_int_r   <= frl_pkg::RST_DOWN_INTERVAL;
      up_step_r  <= frl_pkg::RST_UP_STEP;
      up_int_r   <= frl_pkg::RST_UP_INTERVAL;
    end else if (cfg_we) begin
      case (frl_pkg::cfg_reg_t'(cfg_addr))
        frl_pkg::REG_LIMIT_FREQ:    lim_freq_r <= cfg_wdata[23:0];
        frl_pkg::REG_LIMIT_LEVEL:   lim_lvl_r  <= cfg_wdata[4:0];
        frl_pkg::REG_TOP_LEVEL:     top_lvl_r  <= cfg_wdata[4:0];
        frl_pkg::REG_BUDGET:        budget_r   <= cfg_wdata;
        frl_pkg::REG_DOWN_STEP:     dn_step_r  <= cfg_wdata[5:0];
        frl_pkg::REG_DOWN_INTERVAL: dn_int_r   <= cfg_wdata;
        frl_pkg::REG_UP_STEP:       up_step_r  <= cfg_wdata[5:0];
        frl_pkg::REG_UP_INTERVAL:   up_int_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Offset stays inside its window
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= frl_pkg::OFFSET_LIM)
    else $error("budget offset beyond window");

  // Every item moved on yields a result at the next edge
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("item moved on without a result");

  // Forced unlock leaves the cap at the top level
  a_unlock_top: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && req_r == frl_pkg::REQ_UPDATE && force_unlock) |=> (cap_r == $past(lvl_top)))
    else $error("forced unlock did not restore top level");

  // Over budget implies the stored total reached the base budget
  a_over_base: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg_we) |=> (!ovr_r || accum_r >= 64'(budget_r)))
    else $error("over budget flagged below base budget");
`endif

endmodule

### sim/tb_frequency_residency_limiter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_frequency_residency_limiter_unit: self-checking bench for the limiter
// Drives update and idle-reset items through the stream ports under several
// register settings. A scoreboard class keeps its own copy of the governor
// state, predicts the cap level and over-budget flag of every accepted
// item, and compares each result item in order. Both sides idle at random,
// and the receiver holds off for long stretches so that the block backs up.
// ---------------------------------------------------------------------------
module tb_frequency_residency_limiter_unit;

  localparam logic [63:0] STEP_NS     = 64'(frl_pkg::STEP_MS) * 64'd1000000;
  localparam int          OFFSET_CAP  =
    (frl_pkg::WINDOW_MS / frl_pkg::STEP_MS > 255) ? 255 : frl_pkg::WINDOW_MS / frl_pkg::STEP_MS;
  localparam logic [62:0] T_MAX       = '1;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;
  // no idling on either side inside this window of items
  localparam int          QUIET_FROM  = 600;
  localparam int          QUIET_TO    = 750;

  typedef struct packed {
    logic [4:0] cap_level;
    logic       over_budget;
  } cap_result_t;

  // Governor predictor and result checker
  class residency_scoreboard;
    logic [23:0] thr_freq_khz;
    logic [4:0]  floor_level;
    logic [4:0]  top_level;
    logic [31:0] budget;
    logic [5:0]  down_step;
    logic [31:0] down_interval;
    logic [5:0]  up_step;
    logic [31:0] up_interval;

    logic [63:0] accum;
    logic [63:0] prev_time;
    logic [63:0] last_change;
    logic [4:0]  level;
    logic [7:0]  offset;

    cap_result_t pending_caps[$];
    int errors, n_items, n_forced, n_sat, n_down, n_up, n_over;

    function new();
      thr_freq_khz  = frl_pkg::RST_LIMIT_FREQ;
      floor_level   = frl_pkg::RST_LIMIT_LEVEL;
      top_level     = frl_pkg::RST_TOP_LEVEL;
      budget        = frl_pkg::RST_BUDGET;
      down_step     = frl_pkg::RST_DOWN_STEP;
      down_interval = frl_pkg::RST_DOWN_INTERVAL;
      up_step       = frl_pkg::RST_UP_STEP;
      up_interval   = frl_pkg::RST_UP_INTERVAL;
      accum         = '0;
      prev_time     = '0;
      last_change   = '0;
      level         = to_level(int'(frl_pkg::RST_TOP_LEVEL));
      offset        = '0;
      errors = 0; n_items = 0; n_forced = 0; n_sat = 0;
      n_down = 0; n_up = 0; n_over = 0;
    endfunction

    function logic [4:0] to_level(int v);
      if (v < 0) v = 0;
      if (v > frl_pkg::LEVELS - 1) v = frl_pkg::LEVELS - 1;
      return 5'(v);
    endfunction

    function bit over_now();
      logic [63:0] thr;
      thr = {32'd0, budget} + 64'(offset) * STEP_NS;
      return accum >= thr;
    endfunction

    function void write_reg(frl_pkg::cfg_reg_t r, logic [31:0] v);
      case (r)
        frl_pkg::REG_LIMIT_FREQ:    thr_freq_khz  = v[23:0];
        frl_pkg::REG_LIMIT_LEVEL:   floor_level   = v[4:0];
        frl_pkg::REG_TOP_LEVEL:     top_level     = v[4:0];
        frl_pkg::REG_BUDGET:        budget        = v;
        frl_pkg::REG_DOWN_STEP:     down_step     = v[5:0];
        frl_pkg::REG_DOWN_INTERVAL: down_interval = v;
        frl_pkg::REG_UP_STEP:       up_step       = v[5:0];
        frl_pkg::REG_UP_INTERVAL:   up_interval   = v;
        default: ;
      endcase
    endfunction

    // Advance the governor by one accepted item and queue its result
    function void take_update(frl_pkg::req_kind_t kind, logic [62:0] now_ns,
                              logic [23:0] cur_khz, logic [23:0] floor_khz, logic iso);
      logic [63:0] t, delta, upd;
      logic [64:0] sum;
      bit          unlock;
      int          v, off;
      cap_result_t r;
      t = {1'b0, now_ns};
      n_items++;
      if (kind == frl_pkg::REQ_IDLE_RESET) begin
        if (iso) begin
          prev_time   = t;
          last_change = t;
          accum       = '0;
          level       = to_level(int'(top_level));
        end
      end else begin
        unlock = (floor_khz >= thr_freq_khz) || iso;
        if (unlock) begin
          accum = '0;
          n_forced++;
        end
        // first update after reset or after an idle reset at time zero
        if (prev_time == 64'd0) begin
          prev_time   = t;
          last_change = t;
        end
        delta = (unlock || t < prev_time) ? 64'd0 : t - prev_time;
        upd   = (t < last_change) ? 64'd0 : t - last_change;

        if (cur_khz >= thr_freq_khz) begin
          sum = {1'b0, accum} + {1'b0, delta};
          if (sum[64]) n_sat++;
          accum = sum[64] ? '1 : sum[63:0];
        end else begin
          // exact decay to 80 percent
          accum = (accum / 64'd100) * 64'd80 + ((accum % 64'd100) * 64'd80) / 64'd100;
        end

        if (accum >= {32'd0, budget}) off = int'(offset) + 1;
        else off = int'(offset) >> 1;
        if (off > OFFSET_CAP) off = OFFSET_CAP;
        offset = 8'(off);

        if (over_now()) begin
          if (upd >= {32'd0, down_interval}) begin
            v = int'(level) - int'(down_step);
            if (v < int'(floor_level)) v = int'(floor_level);
            level = to_level(v);
            last_change = t;
            n_down++;
          end
        end else if (upd >= {32'd0, up_interval}) begin
          v = int'(level) + int'(up_step);
          if (v > int'(top_level)) v = int'(top_level);
          level = to_level(v);
          last_change = t;
          n_up++;
        end

        if (unlock) level = to_level(int'(top_level));
        prev_time = t;
      end
      r.cap_level   = level;
      r.over_budget = over_now();
      pending_caps.push_back(r);
    endfunction

    function void check_cap(logic [7:0] d);
      cap_result_t e;
      if (pending_caps.size() == 0) begin
        $error("result with nothing expected: cap_level %0d, over_budget %0d", d[4:0], d[5]);
        errors++;
        return;
      end
      e = pending_caps.pop_front();
      if (d[4:0] !== e.cap_level) begin
        $error("cap_level: expected %0d, actual %0d", e.cap_level, d[4:0]);
        errors++;
      end
      if (d[5] !== e.over_budget) begin
        $error("over_budget: expected %0d, actual %0d", e.over_budget, d[5]);
        errors++;
      end
      if (e.over_budget) n_over++;
    endfunction

    function int outstanding();
      return pending_caps.size();
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata   = '0;  // now_ns[62:0], cur_freq_khz[86:63],
                                  // floor_freq_khz[110:87], isolated[111]
  logic         in_tuser   = 1'b0; // req_type[0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;        // cap_level[4:0], over_budget[5], zero[7:6]
  logic         cfg_we     = 1'b0;
  logic [2:0]   cfg_addr   = '0;
  logic [31:0]  cfg_wdata  = '0;

  residency_scoreboard sb = new();
  int          items_offered = 0;
  int          results_seen  = 0;
  int          quiet_cycles  = 0;
  logic [62:0] timeline      = '0;
  logic [31:0] step_max      = 32'd1;

  frequency_residency_limiter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, long hold-offs at two points, a quiet window
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_cap(out_tdata);
        results_seen++;
        if (results_seen == 300 || results_seen == 900) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one item, with an occasional gap first; returns on acceptance
  task automatic send_item(input frl_pkg::req_kind_t kind, input logic [62:0] now_ns,
                           input logic [23:0] cur_khz, input logic [23:0] floor_khz,
                           input logic iso);
    if (items_offered < QUIET_FROM || items_offered >= QUIET_TO) begin
      while ($urandom_range(0, 99) < 7) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {iso, floor_khz, cur_khz, now_ns};
    do @(posedge clk); while (!in_tready);
    sb.take_update(kind, now_ns, cur_khz, floor_khz, iso);
    items_offered++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input frl_pkg::cfg_reg_t r, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  task automatic set_regs(input logic [23:0] lf, input logic [4:0] ll, input logic [4:0] tl,
                          input logic [31:0] bud, input logic [5:0] ds,
                          input logic [31:0] di, input logic [5:0] us, input logic [31:0] ui);
    drain();
    write_reg(frl_pkg::REG_LIMIT_FREQ,    {8'd0, lf});
    write_reg(frl_pkg::REG_LIMIT_LEVEL,   {27'd0, ll});
    write_reg(frl_pkg::REG_TOP_LEVEL,     {27'd0, tl});
    write_reg(frl_pkg::REG_BUDGET,        bud);
    write_reg(frl_pkg::REG_DOWN_STEP,     {26'd0, ds});
    write_reg(frl_pkg::REG_DOWN_INTERVAL, di);
    write_reg(frl_pkg::REG_UP_STEP,       {26'd0, us});
    write_reg(frl_pkg::REG_UP_INTERVAL,   ui);
    cfg_we <= 1'b0;
  endtask

  // Frequency above (or at) the limit, or below it, often right at the edge
  function automatic logic [23:0] pick_freq(bit above);
    logic [23:0] lim;
    int          r;
    lim = sb.thr_freq_khz;
    r   = $urandom_range(0, 9);
    if (above) return (r < 3) ? lim : lim + 24'($urandom_range(0, 32'(24'hFFFFFF - lim)));
    // nothing lies below a zero limit
    if (lim == 24'd0) return 24'($urandom());
    return (r < 3) ? lim - 24'd1 : 24'($urandom_range(0, 32'(lim - 24'd1)));
  endfunction

  // Mostly well-formed update streams on a rising clock, with bursts of
  // hot and cool running, plus idle resets, backward steps and noise
  task automatic run_phase(input int n);
    int          sent, r, heat;
    logic [31:0] big, d;
    logic [62:0] t;
    bit          above;
    big = sb.budget;
    if (sb.down_interval > big) big = sb.down_interval;
    if (sb.up_interval > big) big = sb.up_interval;
    step_max = big / 32'd4 + 32'd1;
    sent = 0;
    heat = 60;
    send_item(frl_pkg::REQ_IDLE_RESET, timeline, 24'd0, 24'd0, 1'b1);
    while (sent < n) begin
      if (sent % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: heat = 20;
          1: heat = 60;
          default: heat = 95;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // random item, then resynchronise the cluster on the timeline
        send_item(frl_pkg::req_kind_t'($urandom_range(0, 1)), 63'({$urandom(), $urandom()}),
                  24'($urandom()), 24'($urandom()), 1'($urandom()));
        send_item(frl_pkg::REQ_IDLE_RESET, timeline, 24'd0, 24'd0, 1'b1);
        sent += 2;
      end else if (r < 7) begin
        send_item(frl_pkg::REQ_IDLE_RESET, timeline, 24'($urandom()), 24'($urandom()),
                  1'($urandom_range(0, 1)));
        sent++;
      end else begin
        d = $urandom_range(0, step_max);
        if (r < 11) begin
          t = (timeline > 63'(d)) ? timeline - 63'(d) : '0;
        end else begin
          timeline = timeline + 63'(d);
          t = timeline;
        end
        above = ($urandom_range(0, 99) < heat);
        send_item(frl_pkg::REQ_UPDATE, t, pick_freq(above),
                  pick_freq($urandom_range(0, 99) < 5), 1'($urandom_range(0, 99) < 3));
        sent++;
      end
    end
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first update, saturation of the total, exact decay of the
    // saturated total, forced unlocks, idle resets, throttling and recovery
    send_item(frl_pkg::REQ_UPDATE, 63'd1, 24'hFFFFFF, 24'd0, 1'b0);
    for (k = 0; k < 2; k++) begin
      send_item(frl_pkg::REQ_UPDATE, T_MAX, frl_pkg::RST_LIMIT_FREQ, 24'd0, 1'b0);
      send_item(frl_pkg::REQ_UPDATE, 63'd1, frl_pkg::RST_LIMIT_FREQ, 24'd0, 1'b0);
    end
    send_item(frl_pkg::REQ_UPDATE, T_MAX, frl_pkg::RST_LIMIT_FREQ, 24'd0, 1'b0);
    send_item(frl_pkg::REQ_UPDATE, T_MAX, frl_pkg::RST_LIMIT_FREQ - 24'd1, 24'd0, 1'b0);
    send_item(frl_pkg::REQ_UPDATE, T_MAX, 24'd0, frl_pkg::RST_LIMIT_FREQ, 1'b0);
    send_item(frl_pkg::REQ_IDLE_RESET, 63'd5, 24'd0, 24'd0, 1'b0);
    send_item(frl_pkg::REQ_IDLE_RESET, 63'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_item(frl_pkg::REQ_UPDATE, 63'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    for (k = 1; k <= 10; k++)
      send_item(frl_pkg::REQ_UPDATE, 63'(k * 20000000), frl_pkg::RST_LIMIT_FREQ + 24'(k),
                frl_pkg::RST_LIMIT_FREQ - 24'd1, 1'b0);
    for (k = 11; k <= 13; k++)
      send_item(frl_pkg::REQ_UPDATE, 63'(k * 20000000), 24'd0, 24'd0, 1'b0);
    timeline = 63'd260000000;

    run_phase(130);
    // all registers at their lowest: every update is a forced unlock
    set_regs(24'd0, 5'd0, 5'd0, 32'd0, 6'd0, 32'd0, 6'd0, 32'd0);
    run_phase(40);
    // all registers at their highest
    set_regs(24'hFFFFFF, 5'd31, 5'd31, '1, 6'd63, '1, 6'd63, '1);
    run_phase(100);
    // large steps, short intervals
    set_regs(24'd1500000, 5'd0, 5'd31, 32'd5000000, 6'd32, 32'd1000000, 6'd32, 32'd1000000);
    run_phase(150);
    // limit level above the top level
    set_regs(24'd1800000, 5'd20, 5'd8, 32'd10000000, 6'd5, 32'd4000000, 6'd3, 32'd6000000);
    run_phase(150);
    repeat (4) begin
      set_regs(24'($urandom()), 5'($urandom()), 5'($urandom()),
               $urandom() >> $urandom_range(0, 31), 6'($urandom()),
               $urandom() >> $urandom_range(0, 31), 6'($urandom()),
               $urandom() >> $urandom_range(0, 31));
      run_phase(150);
    end
    drain();

    $display("Covered %0d items under 9 register settings: %0d forced unlocks,",
             sb.n_items, sb.n_forced);
    $display("%0d saturated adds, %0d throttle steps, %0d recovery steps, %0d over budget",
             sb.n_sat, sb.n_down, sb.n_up, sb.n_over);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
